// ===== design/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 decoder modules.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   typedef enum logic [0:0] {
      OP_DATA  = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_unit;
   } rsp_type;

   // Open sequence: gathered bits, smallest legal value, continuations expected
   typedef struct packed {
      logic [20:0] partial;
      logic [16:0] minimum;
      logic [1:0]  pending;
   } seq_state_type;

   // Units produced by one item, in order; count is 0, 1 or 2
   typedef struct packed {
      logic [1:0]  count;
      logic [15:0] unit0;
      logic [15:0] unit1;
   } dec_result_type;

   localparam logic [15:0] REPLACEMENT_UNIT = 16'hfffd;
   localparam logic [20:0] MAX_CODE_POINT   = 21'h10ffff;
   localparam logic [20:0] SURROGATE_LOW    = 21'h00d800;
   localparam logic [20:0] SURROGATE_HIGH   = 21'h00dfff;
   localparam logic [20:0] SUPPLEMENTARY    = 21'h010000;
   localparam logic [15:0] HIGH_SURR_BASE   = 16'hd800;
   localparam logic [15:0] LOW_SURR_BASE    = 16'hdc00;
   localparam logic [16:0] MIN_TWO_BYTE     = 17'h00080;
   localparam logic [16:0] MIN_THREE_BYTE   = 17'h00800;
   localparam logic [16:0] MIN_FOUR_BYTE    = 17'h10000;

endpackage

// ===== design/u8u16_decode.sv =====
// ----------------------------------------------------------------------------
// u8u16_decode
// Combinational step: one byte or flush against the open sequence state.
// ----------------------------------------------------------------------------
module u8u16_decode (
   input  u8u16_pkg::req_type        item,
   input  u8u16_pkg::seq_state_type  state,
   output u8u16_pkg::seq_state_type  state_next,
   output u8u16_pkg::dec_result_type result
);
   import u8u16_pkg::*;

   logic [7:0]    b;
   logic          fresh_emit;
   logic [15:0]   fresh_unit;
   seq_state_type fresh_base;
   seq_state_type fresh_state;
   logic [20:0]   cp;
   logic [19:0]   cp_off;
   logic [1:0]    pending_dec;
   logic          cp_bad;

   assign b = item.data_byte;

   // A byte that breaks an open sequence starts again from a cleared state
   assign fresh_base = (item.opcode == OP_DATA && state.pending != 2'd0) ? '0 : state;

   // Fresh byte handling; fresh_base is the state it starts from
   always_comb begin
      fresh_emit  = 1'b0;
      fresh_unit  = REPLACEMENT_UNIT;
      fresh_state = fresh_base;
      if (b[7] == 1'b0) begin
         fresh_emit = 1'b1;
         fresh_unit = {8'h00, b};
      end else if (b >= 8'hc2 && b <= 8'hdf) begin
         fresh_state.partial = {16'h0000, b[4:0]};
         fresh_state.minimum = MIN_TWO_BYTE;
         fresh_state.pending = 2'd1;
      end else if (b >= 8'he0 && b <= 8'hef) begin
         fresh_state.partial = {17'h00000, b[3:0]};
         fresh_state.minimum = MIN_THREE_BYTE;
         fresh_state.pending = 2'd2;
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
         fresh_state.partial = {18'h00000, b[2:0]};
         fresh_state.minimum = MIN_FOUR_BYTE;
         fresh_state.pending = 2'd3;
      end else begin
         fresh_emit = 1'b1;
      end
   end

   assign cp          = {state.partial[14:0], b[5:0]};
   assign cp_off      = 20'(cp - SUPPLEMENTARY);
   assign pending_dec = state.pending - 2'd1;
   assign cp_bad      = (cp < {4'h0, state.minimum}) || (cp > MAX_CODE_POINT) ||
                        (cp >= SURROGATE_LOW && cp <= SURROGATE_HIGH);

   always_comb begin
      state_next   = state;
      result.count = 2'd0;
      result.unit0 = REPLACEMENT_UNIT;
      result.unit1 = REPLACEMENT_UNIT;
      if (item.opcode == OP_FLUSH) begin
         if (state.pending != 2'd0) begin
            state_next   = '0;
            result.count = 2'd1;
         end
      end else if (state.pending != 2'd0) begin
         if (b[7:6] == 2'b10) begin
            state_next.partial = cp;
            state_next.pending = pending_dec;
            if (pending_dec == 2'd0) begin
               state_next.partial = '0;
               if (cp_bad) begin
                  result.count = 2'd1;
               end else if (cp[20:16] == 5'd0) begin
                  result.count = 2'd1;
                  result.unit0 = cp[15:0];
               end else begin
                  result.count = 2'd2;
                  result.unit0 = HIGH_SURR_BASE + {6'h00, cp_off[19:10]};
                  result.unit1 = LOW_SURR_BASE + {6'h00, cp_off[9:0]};
               end
            end
         end else begin
            // Broken sequence: replace, then treat the byte as fresh
            state_next   = fresh_state;
            result.count = fresh_emit ? 2'd2 : 2'd1;
            result.unit1 = fresh_unit;
         end
      end else begin
         state_next   = fresh_state;
         result.count = fresh_emit ? 2'd1 : 2'd0;
         result.unit0 = fresh_unit;
      end
   end

endmodule

// ===== design/u8u16_outbuf.sv =====
// ----------------------------------------------------------------------------
// u8u16_outbuf
// Result register holding up to two code units, drained one unit per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module u8u16_outbuf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  u8u16_pkg::dec_result_type result,
   output logic                      can_take,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output u8u16_pkg::rsp_type        rsp_data
);
   import u8u16_pkg::*;

   logic [1:0]  cnt_ff,   cnt_in;
   logic [15:0] unit0_ff, unit0_in;
   logic [15:0] unit1_ff, unit1_in;
   logic        pop;

   assign rsp_valid          = (cnt_ff != 2'd0);
   assign pop                = rsp_valid && rsp_ready;
   assign can_take           = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);
   assign rsp_data.code_unit = unit0_ff;
   assign rsp_data.last_unit = (cnt_ff == 2'd1);

   always_comb begin
      cnt_in   = cnt_ff;
      unit0_in = unit0_ff;
      unit1_in = unit1_ff;
      if (load) begin
         cnt_in   = result.count;
         unit0_in = result.unit0;
         unit1_in = result.unit1;
      end else if (pop) begin
         // shift the second unit forward
         cnt_in   = cnt_ff - 2'd1;
         unit0_in = unit1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      unit0_ff <= unit0_in;
      unit1_ff <= unit1_in;
   end

endmodule

// ===== design/utf8_to_utf16_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// UTF-8 byte stream to UTF-16 code units with replacement on bad input.
// ----------------------------------------------------------------------------
// Bytes enter an input register, are decoded combinationally against the open
// sequence and land in a two-unit result register. For items that yield zero
// or one code unit a byte can be accepted every cycle while the result side
// keeps up; an item that yields two units (surrogate pair, or a broken
// sequence followed by a byte that emits) holds the input stage until the
// result register is down to its last unit. The first unit of an item passes
// through the input register and the result register. A flush item replaces
// an unfinished sequence with U+FFFD; last_unit marks the final unit of each
// item.
module utf8_to_utf16_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  u8u16_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output u8u16_pkg::rsp_type rsp_data
);
   import u8u16_pkg::*;

   logic           in_valid_ff, in_valid_in;
   req_type        in_item_ff,  in_item_in;
   seq_state_type  state_ff,    state_in;
   seq_state_type  state_next;
   dec_result_type result;
   logic           can_take;
   logic           advance;
   logic           accept;

   assign advance   = in_valid_ff && can_take;
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   u8u16_decode u_decode (
      .item       (in_item_ff),
      .state      (state_ff),
      .state_next (state_next),
      .result     (result)
   );

   u8u16_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      state_in    = state_ff;
      if (advance) begin
         in_valid_in = 1'b0;
         state_in    = state_next;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
      in_item_ff <= in_item_in;
   end

endmodule
